@@ hdl/indexed_dual_stack_deque_core_assert.svh @@
// Assertion macros for the indexed dual-stack deque core.
`ifndef INDEXED_DUAL_STACK_DEQUE_CORE_ASSERT_SVH
`define INDEXED_DUAL_STACK_DEQUE_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define IDSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define IDSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/idsd_pkg.sv @@
// Shared types, constants and helper functions of the indexed dual-stack deque.
package idsd_pkg;

  localparam int CAPACITY  = 32;
  localparam int WORD_BITS = 32;

  // Fixed widths of the transfer fields
  localparam int FIELD_W = 6;
  localparam int VALUE_W = 32;

  // Internal widths derived from the capacity
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_SET    = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] position;
    logic [VALUE_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    logic               ok;
    logic [FIELD_W-1:0] count;
  } out_item_t;

  // Command broadcast from the control logic to every cell
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             write;
    logic [CMP_W-1:0] pos;
    word_t            data;
  } cell_cmd_t;

  // Fit a transfer value to the stored word width
  function automatic word_t word_from_field(input logic [VALUE_W-1:0] v);
    logic [WORD_BITS+VALUE_W-1:0] t;
    t = {{WORD_BITS{1'b0}}, v};
    return t[WORD_BITS-1:0];
  endfunction

  // Fit a stored word back to the transfer value width
  function automatic logic [VALUE_W-1:0] field_from_word(input word_t w);
    logic [WORD_BITS+VALUE_W-1:0] t;
    t = {{VALUE_W{1'b0}}, w};
    return t[VALUE_W-1:0];
  endfunction

endpackage

@@ hdl/idsd_cell.sv @@
// One list cell: holds the word at its list position and shifts with its neighbors.
module idsd_cell (
  input  logic                          clk,
  input  idsd_pkg::cell_cmd_t           cmd,
  input  logic [idsd_pkg::IDX_W-1:0]    idx,
  input  idsd_pkg::word_t               lower_word,
  input  idsd_pkg::word_t               upper_word,
  output idsd_pkg::word_t               word_o,
  output idsd_pkg::word_t               rd_word
);

  idsd_pkg::word_t               word_r;
  idsd_pkg::word_t               word_nxt;
  logic [idsd_pkg::CMP_W-1:0]    idx_x;
  logic                          at_pos;
  logic                          above;

  // Compare own position against the commanded one
  assign idx_x  = {{(idsd_pkg::CMP_W - idsd_pkg::IDX_W){1'b0}}, idx};
  assign at_pos = (idx_x == cmd.pos);
  assign above  = (idx_x > cmd.pos);

  // Next word: below on insert, above on remove, cmd.data at pos on set or insert
  always_comb begin
    priority if (cmd.shift_up && above) begin
      word_nxt = lower_word;
    end else if ((cmd.shift_up || cmd.write) && at_pos) begin
      word_nxt = cmd.data;
    end else if (cmd.shift_down && (above || at_pos)) begin
      word_nxt = upper_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o  = word_r;
  assign rd_word = at_pos ? word_r : '0;

endmodule

@@ hdl/indexed_dual_stack_deque_core.sv @@
// Top level of the indexed dual-stack deque: control, cell chain and result register.
//
// Usage:
//   in_valid/in_stall/in_data carry one operation: get, set, insert or remove
//   at a list position. out_valid/out_stall/out_data return exactly one result
//   per operation: the word read, replaced or removed, an ok flag and the new
//   element count.
//   The list lives in a row of CAPACITY cells, one word per list position.
//   An insert shifts every cell above the position up by one and a remove
//   shifts them down, all in the same clock edge, so the list keeps the order
//   of the front stack reversed followed by the back stack.
//   The result appears in the cycle after the transfer is accepted.
//   Throughput: one operation per cycle while no result is held by out_stall; the
//   cell row updates at the accepting edge and the result register drains in parallel.
//   An insert into a full list, or an access beyond the count, returns ok low,
//   value zero, and leaves the list untouched.
//   Reset: rst_n low clears the count and the result valid flag; cell words are
//   not cleared and are only read after being written.
//   Stall: while out_stall holds a waiting result, in_stall is raised and the
//   result stays unchanged.
module indexed_dual_stack_deque_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  idsd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output idsd_pkg::out_item_t  out_data
);

  `include "indexed_dual_stack_deque_core_assert.svh"

  logic [idsd_pkg::CNT_W-1:0]    cnt_r;
  logic [idsd_pkg::CNT_W-1:0]    cnt_nxt;
  logic                          out_valid_r;
  idsd_pkg::out_item_t           out_data_r;

  logic                          accept;
  logic [idsd_pkg::CMP_W-1:0]    pos_x;
  logic [idsd_pkg::CMP_W-1:0]    cnt_x;
  logic [idsd_pkg::CMP_W-1:0]    cnt_nxt_x;
  logic                          in_range;
  logic                          ins_range;
  logic                          op_ok;
  idsd_pkg::cell_cmd_t           cmd;
  idsd_pkg::word_t               rd_any;
  idsd_pkg::out_item_t           result;

  idsd_pkg::word_t               word_w [idsd_pkg::CAPACITY];
  idsd_pkg::word_t               rd_w   [idsd_pkg::CAPACITY];

  // Accept while the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Range checks against the current count
  assign pos_x     = {{(idsd_pkg::CMP_W - idsd_pkg::FIELD_W){1'b0}}, in_data.position};
  assign cnt_x     = {{(idsd_pkg::CMP_W - idsd_pkg::CNT_W){1'b0}}, cnt_r};
  assign in_range  = (pos_x < cnt_x);
  assign ins_range = (pos_x <= cnt_x) && (cnt_x < idsd_pkg::CMP_W'(idsd_pkg::CAPACITY));

  always_comb begin
    unique case (in_data.kind)
      idsd_pkg::KIND_GET:    op_ok = in_range;
      idsd_pkg::KIND_SET:    op_ok = in_range;
      idsd_pkg::KIND_INSERT: op_ok = ins_range;
      idsd_pkg::KIND_REMOVE: op_ok = in_range;
      default:               op_ok = 1'b0;
    endcase
  end

  // Broadcast the command to the cell row
  always_comb begin
    cmd.shift_up   = accept && op_ok && (in_data.kind == idsd_pkg::KIND_INSERT);
    cmd.shift_down = accept && op_ok && (in_data.kind == idsd_pkg::KIND_REMOVE);
    cmd.write      = accept && op_ok && (in_data.kind == idsd_pkg::KIND_SET);
    cmd.pos        = pos_x;
    cmd.data       = idsd_pkg::word_from_field(in_data.value_in);
  end

  // Build the cell chain; the end cells take their own word as the missing neighbor
  for (genvar i = 0; i < idsd_pkg::CAPACITY; i++) begin : g_cell
    idsd_pkg::word_t lower_w;
    idsd_pkg::word_t upper_w;
    if (i == 0) begin : g_first
      assign lower_w = word_w[i];
    end else begin : g_mid_lo
      assign lower_w = word_w[i-1];
    end
    if (i == idsd_pkg::CAPACITY - 1) begin : g_last
      assign upper_w = word_w[i];
    end else begin : g_mid_hi
      assign upper_w = word_w[i+1];
    end
    idsd_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idsd_pkg::IDX_W'(i)),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word_o     (word_w[i]),
      .rd_word    (rd_w[i])
    );
  end

  // Merge the one selected cell word
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < idsd_pkg::CAPACITY; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  // Advance the count
  always_comb begin
    priority if (cmd.shift_up) begin
      cnt_nxt = cnt_r + idsd_pkg::CNT_W'(1);
    end else if (cmd.shift_down) begin
      cnt_nxt = cnt_r - idsd_pkg::CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign cnt_nxt_x = {{(idsd_pkg::CMP_W - idsd_pkg::CNT_W){1'b0}}, cnt_nxt};

  // Form the result item
  always_comb begin
    result.value_out = (op_ok && (in_data.kind != idsd_pkg::KIND_INSERT)) ?
                       idsd_pkg::field_from_word(rd_any) : '0;
    result.ok        = op_ok;
    result.count     = cnt_nxt_x[idsd_pkg::FIELD_W-1:0];
  end

  // Hold count and result register; drop the result once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `IDSD_ASSERT_SAME(a_cnt_max, 1'b1, cnt_r <= idsd_pkg::CNT_W'(idsd_pkg::CAPACITY), "count above capacity")
  `IDSD_ASSERT_NEXT(a_refused_keeps, accept && !op_ok, cnt_r == $past(cnt_r), "refused op changed count")
  `IDSD_ASSERT_NEXT(a_insert_grows, cmd.shift_up, cnt_r == $past(cnt_r) + idsd_pkg::CNT_W'(1), "insert count")
  `IDSD_ASSERT_NEXT(a_result_shown, accept, out_valid_r && (out_data_r.ok == $past(op_ok)), "result lost")

endmodule
